/* design/dpms_pkg.sv */
package dpms_pkg;

  localparam int unsigned ANGLE_FRAC_BITS = 16;

  localparam int unsigned LAT_W = 25;
  localparam int unsigned OUT_W = 48;

  localparam int unsigned QW = ANGLE_FRAC_BITS + 7;
  localparam int unsigned TW = ANGLE_FRAC_BITS + 10;
  localparam int unsigned XW = 31;
  localparam int unsigned XS = ANGLE_FRAC_BITS + 10;
  localparam int unsigned RW = ANGLE_FRAC_BITS + 12;
  localparam int unsigned EW = QW + 35;

  localparam logic [TW-1:0] FULL_TURN = TW'(360) << ANGLE_FRAC_BITS;
  localparam logic [TW-1:0] HALF_TURN = TW'(180) << ANGLE_FRAC_BITS;
  localparam logic [TW-1:0] QUARTER_TURN = TW'(90) << ANGLE_FRAC_BITS;
  localparam logic [LAT_W-1:0] LAT_LIMIT = LAT_W'(90) << ANGLE_FRAC_BITS;

  localparam logic [33:0] PI_Q32 = 34'd13493037705;
  localparam logic [34:0] X_COEF = 35'((64'd13493037705 * 64'd64) / 64'd45);
  localparam logic [RW-1:0] DEN = RW'(45) << (ANGLE_FRAC_BITS + 4);
  localparam logic [RW-1:0] HALF_DEN = RW'(45) << (ANGLE_FRAC_BITS + 3);

  localparam int unsigned HORNER_STEPS = 8;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  typedef logic signed [31:0] cos_t;

  localparam logic signed [31:0] CF1 = 32'sd1114128400;
  localparam logic signed [31:0] CF2 = -32'sd935000;
  localparam logic signed [31:0] CF3 = 32'sd1180;
  localparam logic signed [31:0] CF5 = -32'sd5598200;
  localparam logic signed [31:0] CF6 = 32'sd11750;
  localparam logic signed [31:0] CF7 = 32'sd23;
  localparam logic signed [63:0] LAT_BASE = 64'sd1111329200 * 64'sd1073741824;

  localparam logic [63:0] RECIP_NUM = 64'd11258999068426240000;
  localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

  localparam int unsigned DW = 44;
  localparam int unsigned QR_W = DW + 1;
  localparam int unsigned DIV_STEPS = OUT_W;

  localparam int unsigned COS_LAT = 6 + 2 * HORNER_STEPS;
  localparam int unsigned RECIP_LAT = DIV_STEPS + 3;
  localparam int unsigned PIPE_LAT = 1 + COS_LAT + 2 + RECIP_LAT;

  function automatic int unsigned horner_tz(input int unsigned i);
    unique case (i)
      0: return 4;
      1: return 1;
      2: return 2;
      3: return 1;
      4: return 3;
      5: return 1;
      6: return 2;
      default: return 1;
    endcase
  endfunction

  function automatic int unsigned horner_odd(input int unsigned i);
    unique case (i)
      0: return 15;
      1: return 91;
      2: return 33;
      3: return 45;
      4: return 7;
      5: return 15;
      6: return 3;
      default: return 1;
    endcase
  endfunction

  function automatic int unsigned horner_sh(input int unsigned i);
    unique case (i)
      0: return 36;
      1: return 39;
      2: return 38;
      3: return 38;
      4: return 35;
      5: return 36;
      6: return 34;
      default: return 32;
    endcase
  endfunction

endpackage

/* design/dpms_cos.sv */
module dpms_cos (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [2:0]                k_i,
  input  logic [dpms_pkg::QW-1:0]   mag_i,
  output dpms_pkg::cos_t            cos_o
);

  localparam int unsigned QW = dpms_pkg::QW;
  localparam int unsigned TW = dpms_pkg::TW;
  localparam int unsigned XW = dpms_pkg::XW;
  localparam int unsigned XS = dpms_pkg::XS;
  localparam int unsigned RW = dpms_pkg::RW;
  localparam int unsigned EW = dpms_pkg::EW;
  localparam int unsigned HS = dpms_pkg::HORNER_STEPS;
  localparam int unsigned ND = dpms_pkg::COS_LAT - 1;

  logic [TW-1:0] t, r1, r2, r3;
  logic          neg;

  logic [QW-1:0] r_q;
  logic          neg_q [ND];
  logic [EW-1:0] est_q;
  logic [RW-1:0] alow_q, alow2_q;
  logic [XW-1:0] e_q, x_q;
  logic [31:0]   s_q;

  logic [EW-1:0] est_d;
  logic [RW-1:0] alow_d, rem;
  logic [XW-1:0] e_d, x_d;
  logic [31:0]   s_d;

  logic [62:0]   hp_q [HS];
  logic [31:0]   hsp_q [HS];
  logic [31:0]   hq_q [HS];
  logic [31:0]   hsq_q [HS];

  logic [32:0]   hm [HS];
  logic [31:0]   s_in [HS];
  logic [31:0]   q_in [HS];
  logic [30:0]   v [HS];
  logic [31:0]   y [HS];
  logic [64:0]   prod [HS];

  dpms_pkg::cos_t c_pos, cos_q;

  always_comb begin
    t = TW'(mag_i) * TW'(k_i);
    r1 = (t >= dpms_pkg::FULL_TURN) ? t - dpms_pkg::FULL_TURN : t;
    r2 = (r1 > dpms_pkg::HALF_TURN) ? dpms_pkg::FULL_TURN - r1 : r1;
    neg = r2 > dpms_pkg::QUARTER_TURN;
    r3 = neg ? dpms_pkg::HALF_TURN - r2 : r2;
  end

  assign est_d = EW'(r_q) * EW'(dpms_pkg::X_COEF);
  assign alow_d = RW'(RW'(r_q) * RW'(dpms_pkg::PI_Q32) + dpms_pkg::HALF_DEN);
  assign e_d = XW'((est_q + (EW'(1) << (XS - 1))) >> XS);
  assign rem = alow2_q - RW'(RW'(e_q) * dpms_pkg::DEN);
  assign x_d = (rem >= dpms_pkg::DEN) ? e_q + XW'(1) : e_q;
  assign s_d = 32'((62'(x_q) * 62'(x_q) + (62'(1) << 29)) >> 30);

  for (genvar i = 0; i < HS; i++) begin : g_hm
    localparam int unsigned Sh = dpms_pkg::horner_sh(i);
    localparam int unsigned Odd = dpms_pkg::horner_odd(i);
    localparam logic [32:0] Hm =
      33'(((65'd1 << Sh) + 65'(Odd) - 65'd1) / 65'(Odd));
    assign hm[i] = Hm;
  end

  always_comb begin
    for (int i = 0; i < HS; i++) begin
      s_in[i] = (i == 0) ? s_q : hsq_q[(i == 0) ? 0 : i - 1];
      q_in[i] = (i == 0) ? 32'd0 : hq_q[(i == 0) ? 0 : i - 1];
      v[i] = dpms_pkg::ONE_Q30 - 31'(q_in[i]);
      y[i] = hp_q[i][61:30] >> dpms_pkg::horner_tz(i);
      prod[i] = 65'(y[i]) * 65'(hm[i]);
    end
  end

  assign c_pos = $signed({2'b01, 30'd0}) - $signed(hq_q[HS-1]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q <= QW'(r3);
      neg_q[0] <= neg;
      for (int j = 1; j < ND; j++) begin
        neg_q[j] <= neg_q[j-1];
      end
      est_q <= est_d;
      alow_q <= alow_d;
      e_q <= e_d;
      alow2_q <= alow_q;
      x_q <= x_d;
      s_q <= s_d;
      for (int i = 0; i < HS; i++) begin
        hp_q[i] <= 63'(s_in[i]) * 63'(v[i]);
        hsp_q[i] <= s_in[i];
        hq_q[i] <= 32'(prod[i] >> dpms_pkg::horner_sh(i));
        hsq_q[i] <= hsp_q[i];
      end
      cos_q <= neg_q[ND-1] ? -c_pos : c_pos;
    end
  end

  assign cos_o = cos_q;

endmodule

/* design/dpms_recip.sv */
module dpms_recip (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic signed [63:0]           sum_i,
  output logic [dpms_pkg::OUT_W-1:0]   res_o
);

  localparam int unsigned DW = dpms_pkg::DW;
  localparam int unsigned QR_W = dpms_pkg::QR_W;
  localparam int unsigned OW = dpms_pkg::OUT_W;
  localparam int unsigned NS = dpms_pkg::DIV_STEPS;

  logic [63:0]     mag;
  logic [DW-1:0]   d_d;
  logic [63:0]     nn_d;
  logic [DW-1:0]   d_q;
  logic [63:0]     nn_q;
  logic            sat0;

  logic [QR_W-1:0] rm_q [NS+1];
  logic [OW-1:0]   lo_q [NS+1];
  logic [OW-1:0]   qt_q [NS+1];
  logic [DW-1:0]   dv_q [NS+1];
  logic            sat_q [NS+1];

  logic [QR_W-1:0] trial [NS];
  logic            ge [NS];
  logic [QR_W-1:0] rm_d [NS];

  logic [OW-1:0]   res_q;

  always_comb begin
    mag = sum_i[63] ? 64'(-sum_i) : 64'(sum_i);
    d_d = DW'((mag + 64'd524288) >> 20);
    nn_d = dpms_pkg::RECIP_NUM + 64'(d_d >> 1);
    sat0 = {28'd0, nn_q} >= {d_q, 48'd0};
  end

  always_comb begin
    for (int j = 0; j < NS; j++) begin
      trial[j] = {rm_q[j][QR_W-2:0], lo_q[j][OW-1]};
      ge[j] = trial[j] >= {1'b0, dv_q[j]};
      rm_d[j] = ge[j] ? trial[j] - {1'b0, dv_q[j]} : trial[j];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q <= d_d;
      nn_q <= nn_d;
      rm_q[0] <= QR_W'(nn_q[63:48]);
      lo_q[0] <= nn_q[OW-1:0];
      qt_q[0] <= '0;
      dv_q[0] <= d_q;
      sat_q[0] <= sat0;
      for (int j = 0; j < NS; j++) begin
        rm_q[j+1] <= rm_d[j];
        lo_q[j+1] <= lo_q[j] << 1;
        qt_q[j+1] <= {qt_q[j][OW-2:0], ge[j]};
        dv_q[j+1] <= dv_q[j];
        sat_q[j+1] <= sat_q[j];
      end
      res_q <= sat_q[NS] ? dpms_pkg::OUT_MAX : qt_q[NS];
    end
  end

  assign res_o = res_q;

endmodule

/* design/degree_per_meter_scale_core.sv */
// Converts a latitude into degree-per-meter scale factors on the WGS84 ellipsoid.
// The input channel carries a signed latitude in units of 2^-16 degree on
// latitude_deg_i, under in_valid_i and in_ready_o. The output channel carries
// the longitude and latitude scale factors in units of 2^-40 degree per meter
// and a status bit, under out_valid_o and out_ready_i.
// Every stage is a register of one fixed pipeline, so a new request is taken
// in every cycle while the output side keeps up. The pipeline is 76 stages deep,
// set by the 48-stage radix-2 divider behind 22 cosine stages.
// A latitude beyond 90 degrees gives status 1 and zero scale factors, and a
// longitude factor too large to represent saturates at the field maximum.
// Reset clears only the stage valid bits, so the pipeline comes up empty.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// in_ready_o falls; it resumes without losing or repeating a request.
module degree_per_meter_scale_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [dpms_pkg::LAT_W-1:0]    latitude_deg_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [dpms_pkg::OUT_W-1:0]           lon_deg_per_meter_o,
  output logic [dpms_pkg::OUT_W-1:0]           lat_deg_per_meter_o,
  output logic                                 status_o
);

  localparam int unsigned PL = dpms_pkg::PIPE_LAT;
  localparam int unsigned QW = dpms_pkg::QW;
  localparam int unsigned LW = dpms_pkg::LAT_W;

  logic          en;
  logic          vld_q [PL];
  logic          err_q [PL];
  logic [LW-1:0] mag_in;
  logic          err_in;
  logic [QW-1:0] mag_q;

  dpms_pkg::cos_t cosv [6];
  logic signed [63:0] p_q [6];
  logic signed [63:0] slon_q, slat_q;
  logic [dpms_pkg::OUT_W-1:0] lon_res, lat_res;

  assign en = !vld_q[PL-1] || out_ready_i;
  assign in_ready_o = en;

  assign mag_in = latitude_deg_i[LW-1] ? LW'(-latitude_deg_i) : LW'(latitude_deg_i);
  assign err_in = mag_in > dpms_pkg::LAT_LIMIT;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PL; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else if (en) begin
      vld_q[0] <= in_valid_i;
      for (int i = 1; i < PL; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag_q <= QW'(mag_in);
      err_q[0] <= err_in;
      for (int i = 1; i < PL; i++) begin
        err_q[i] <= err_q[i-1];
      end
      p_q[0] <= 64'(dpms_pkg::CF1) * 64'(cosv[0]);
      p_q[1] <= 64'(dpms_pkg::CF2) * 64'(cosv[2]);
      p_q[2] <= 64'(dpms_pkg::CF3) * 64'(cosv[4]);
      p_q[3] <= 64'(dpms_pkg::CF5) * 64'(cosv[1]);
      p_q[4] <= 64'(dpms_pkg::CF6) * 64'(cosv[3]);
      p_q[5] <= 64'(dpms_pkg::CF7) * 64'(cosv[5]);
      slon_q <= p_q[0] + p_q[1] + p_q[2];
      slat_q <= dpms_pkg::LAT_BASE + p_q[3] + p_q[4] + p_q[5];
    end
  end

  for (genvar k = 0; k < 6; k++) begin : g_cos
    dpms_cos u_cos (
      .clk_i (clk_i),
      .en_i  (en),
      .k_i   (3'(k + 1)),
      .mag_i (mag_q),
      .cos_o (cosv[k])
    );
  end

  dpms_recip u_recip_lon (
    .clk_i (clk_i),
    .en_i  (en),
    .sum_i (slon_q),
    .res_o (lon_res)
  );

  dpms_recip u_recip_lat (
    .clk_i (clk_i),
    .en_i  (en),
    .sum_i (slat_q),
    .res_o (lat_res)
  );

  assign out_valid_o = vld_q[PL-1];
  assign status_o = err_q[PL-1];
  assign lon_deg_per_meter_o = err_q[PL-1] ? '0 : lon_res;
  assign lat_deg_per_meter_o = err_q[PL-1] ? '0 : lat_res;

endmodule

/* test/degree_per_meter_scale_core_tb.sv */
module degree_per_meter_scale_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dpms_pkg::*;

  localparam int unsigned FRAC = ANGLE_FRAC_BITS;
  localparam int LAT_MAX_UNITS = 90 << FRAC;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 120;

  localparam logic [63:0] PI_Q32_TB = 64'd13493037705;
  localparam longint ONE_Q30_TB = 64'sd1073741824;
  localparam logic [63:0] SCALE_NUM = 64'd11258999068426240000;
  localparam logic [47:0] FIELD_MAX = 48'hFFFF_FFFF_FFFF;
  localparam longint LON_C1 = 1114128400;
  localparam longint LON_C3 = -935000;
  localparam longint LON_C5 = 1180;
  localparam longint LAT_C0 = 1111329200;
  localparam longint LAT_C2 = -5598200;
  localparam longint LAT_C4 = 11750;
  localparam longint LAT_C6 = 23;

  typedef struct packed {
    logic [47:0] lon;
    logic [47:0] lat;
    logic        status;
  } scale_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic signed [LAT_W-1:0] latitude_deg_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic [OUT_W-1:0]        lon_deg_per_meter_o;
  logic [OUT_W-1:0]        lat_deg_per_meter_o;
  logic                    status_o;

  scale_t pending_scales[$];
  int     error_count;
  int     request_count;
  int     result_count;
  int     out_of_range_count;
  int     saturated_count;
  int     hold_off_cycles;
  int     cycle_count;

  degree_per_meter_scale_core uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .latitude_deg_i     (latitude_deg_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .lon_deg_per_meter_o(lon_deg_per_meter_o),
    .lat_deg_per_meter_o(lat_deg_per_meter_o),
    .status_o           (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint cosine_q30(input logic [31:0] angle);
    logic [31:0] r;
    logic        neg;
    logic [63:0] den;
    logic [63:0] x;
    logic [63:0] sq;
    longint      s;
    longint      v;
    longint      divs[8];
    divs = '{240, 182, 132, 90, 56, 30, 12, 2};
    r = angle % (32'd360 << FRAC);
    neg = 1'b0;
    if (r > (32'd180 << FRAC)) r = (32'd360 << FRAC) - r;
    if (r > (32'd90 << FRAC)) begin
      r = (32'd180 << FRAC) - r;
      neg = 1'b1;
    end
    den = 64'd180 << (FRAC + 2);
    x = ({32'd0, r} * PI_Q32_TB + (den >> 1)) / den;
    sq = (x * x + (64'd1 << 29)) >> 30;
    s = longint'(sq);
    v = ONE_Q30_TB;
    for (int i = 0; i < 8; i++) v = ONE_Q30_TB - (s * v) / (divs[i] <<< 30);
    return neg ? -v : v;
  endfunction

  function automatic logic [47:0] degrees_per_meter(input longint series);
    logic [63:0] mag;
    logic [63:0] d;
    logic [63:0] q;
    mag = (series < 0) ? 64'(-series) : 64'(series);
    d = (mag + (64'd1 << 19)) >> 20;
    if (d == 0) return FIELD_MAX;
    q = (SCALE_NUM + (d >> 1)) / d;
    return (q > {16'd0, FIELD_MAX}) ? FIELD_MAX : q[47:0];
  endfunction

  function automatic scale_t predict_scale(input logic [LAT_W-1:0] raw);
    scale_t      res;
    logic [31:0] mag;
    longint      c[7];
    mag = raw[LAT_W-1] ? (32'h200_0000 - {7'd0, raw}) : {7'd0, raw};
    res = '0;
    if (mag > LAT_MAX_UNITS) begin
      res.status = 1'b1;
      return res;
    end
    c[0] = ONE_Q30_TB;
    for (int k = 1; k <= 6; k++) c[k] = cosine_q30(k * mag);
    res.lon = degrees_per_meter(LON_C1 * c[1] + LON_C3 * c[3] + LON_C5 * c[5]);
    res.lat = degrees_per_meter(LAT_C0 * c[0] + LAT_C2 * c[2] + LAT_C4 * c[4] +
                                LAT_C6 * c[6]);
    return res;
  endfunction

  task automatic send_latitude(input int lat);
    scale_t exp_scale;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    latitude_deg_i <= LAT_W'(lat);
    do @(posedge clk_i); while (!in_ready_o);
    exp_scale = predict_scale(LAT_W'(lat));
    if (exp_scale.status) out_of_range_count++;
    if (exp_scale.lon == FIELD_MAX) saturated_count++;
    pending_scales.push_back(exp_scale);
    request_count++;
  endtask

  task automatic idle_input(input int n);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  task automatic wait_drained();
    while (pending_scales.size() != 0) @(posedge clk_i);
  endtask

  function automatic int random_latitude();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) return int'($urandom_range(0, 2 * LAT_MAX_UNITS)) - LAT_MAX_UNITS;
    if (pick < 8) return ($urandom_range(0, 1) ? 1 : -1) *
                         (LAT_MAX_UNITS - int'($urandom_range(0, 4096)));
    if (pick < 9) return ($urandom_range(0, 1) ? 1 : -1) *
                         (LAT_MAX_UNITS + int'($urandom_range(0, 16)));
    return int'($urandom & 32'h1FF_FFFF) - (1 << 24);
  endfunction

  task automatic send_random_bursts(input int total);
    int sent;
    int burst;
    sent = 0;
    while (sent < total) begin
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst && sent < total; i++) begin
        send_latitude(random_latitude());
        sent++;
      end
      if ($urandom_range(0, 3) != 0) idle_input($urandom_range(1, 12));
    end
    idle_input(1);
  endtask

  task automatic test_field_extremes();
    int lats[$];
    lats = {0, 1, -1, LAT_MAX_UNITS, -LAT_MAX_UNITS, LAT_MAX_UNITS - 1,
            -(LAT_MAX_UNITS - 1), LAT_MAX_UNITS + 1, -(LAT_MAX_UNITS + 1),
            (1 << 24) - 1, -(1 << 24), 45 << FRAC, -(45 << FRAC), 30 << FRAC,
            60 << FRAC, 89 << FRAC, 180 << FRAC, -(270 << FRAC), 12345, -98765,
            32'h0AA_AAAA, -32'h055_5555};
    foreach (lats[i]) send_latitude(lats[i]);
    idle_input(1);
    wait_drained();
  endtask

  task automatic test_random_stream();
    send_random_bursts(1200);
  endtask

  task automatic test_output_backpressure();
    @(negedge clk_i);
    hold_off_cycles = 300;
    for (int i = 0; i < 200; i++) send_latitude(random_latitude());
    idle_input(1);
  endtask

  task automatic test_pause_until_drained();
    wait_drained();
    send_random_bursts(130);
    wait_drained();
  endtask

  always @(negedge clk_i) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_ready_i <= 1'b0;
    end else begin
      case ((cycle_count / 97) % 4)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= ($urandom_range(0, 1) == 0);
        2: out_ready_i <= ((cycle_count % 7) < 5);
        default: out_ready_i <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    scale_t exp_scale;
    if (rst_ni && out_valid_o && out_ready_i) begin
      result_count++;
      if (pending_scales.size() == 0) begin
        $display("%0t: result with no request outstanding: lon %h lat %h status %b",
                 $time, lon_deg_per_meter_o, lat_deg_per_meter_o, status_o);
        error_count++;
      end else begin
        exp_scale = pending_scales.pop_front();
        if (lon_deg_per_meter_o !== exp_scale.lon) begin
          $display("%0t: lon mismatch: expected %h actual %h", $time, exp_scale.lon,
                   lon_deg_per_meter_o);
          error_count++;
        end
        if (lat_deg_per_meter_o !== exp_scale.lat) begin
          $display("%0t: lat mismatch: expected %h actual %h", $time, exp_scale.lat,
                   lat_deg_per_meter_o);
          error_count++;
        end
        if (status_o !== exp_scale.status) begin
          $display("%0t: status mismatch: expected %b actual %b", $time,
                   exp_scale.status, status_o);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles.", cycle_count);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    cycle_count = 0;
    error_count = 0;
    request_count = 0;
    result_count = 0;
    out_of_range_count = 0;
    saturated_count = 0;
    hold_off_cycles = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    latitude_deg_i = '0;
    out_ready_i = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_field_extremes();
    test_random_stream();
    test_output_backpressure();
    test_pause_until_drained();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_scales.size() != 0) begin
      $display("%0d results never arrived.", pending_scales.size());
      error_count++;
    end
    $display("Sent %0d latitudes and checked %0d results under random stalls.",
             request_count, result_count);
    $display("%0d were out of range and %0d had a saturated longitude factor.",
             out_of_range_count, saturated_count);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
